FILE: design/uart_fc_pkg.sv
`default_nettype none

package uart_fc_pkg;

  // Item operation codes
  typedef enum logic [2:0] {
    OP_RX_BYTE       = 3'd0,
    OP_POP           = 3'd1,
    OP_SEND          = 3'd2,
    OP_RTS_CHANGE    = 3'd3,
    OP_TX_EMPTY      = 3'd4,
    OP_RESET_RELEASE = 3'd5,
    OP_TX_COMPLETE   = 3'd6
  } op_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_ASSERT_FREE_BELOW  = 2'd0,
    CFG_RELEASE_FILL_BELOW = 2'd1
  } cfg_idx_e;

  localparam int unsigned ThrW = 6;
  localparam logic [ThrW-1:0] AssertFreeBelowRst  = 6'd5;
  localparam logic [ThrW-1:0] ReleaseFillBelowRst = 6'd16;

  // Input item
  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] data_byte;
    logic       rts_high;
    logic       tx_ready;
  } uart_fc_in_t;

  // Result item
  typedef struct packed {
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       send_done;
    logic       cts_level;
    logic [5:0] fill_count;
    logic       overflow;
  } uart_fc_out_t;

  // Receive ring result, registered
  typedef struct packed {
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       cts_level;
    logic [5:0] fill_count;
    logic       overflow;
  } ring_res_t;

  // Transmit gate commands
  typedef struct packed {
    logic send;
    logic attempt;
    logic release_rst;
    logic complete;
  } tx_cmd_t;

  // Transmit gate result, registered
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       send_done;
  } tx_res_t;

endpackage

`default_nettype wire

FILE: design/uart_flow_control_fifo_core.sv
`default_nettype none

// UART link end with RTS/CTS flow control and a receive ring.
// Items come in on item_i, taken at a clock edge with start high (busy is
// always low, so one item can be taken every cycle). Each item is one of:
// receive byte, pop, send, RTS change, transmit empty, reset release,
// transmit complete; any other code only reports status.
// Every item gives exactly one result on result_o, shown for one cycle with
// result_valid_o high: the item passes from the input register through the
// ring and gate logic, whose outputs and the ring read port are registered,
// and the result then stands on the ports. Throughput is one item per cycle;
// the ring memory has one write and one read port.
// The receiver cannot stall; results are never held or repeated.
// Thresholds are written on the cfg channel (always ready): index 0 is the
// CTS assert level on free space, index 1 the release level on fill. The user
// must write them only while no item is in flight; the block does not enforce it.
// Reset empties the ring, drops CTS, clears the pending transmit byte and
// puts the link end in its own reset state until a reset release item.
module uart_flow_control_fifo_core import uart_fc_pkg::*; #(
  parameter int unsigned RING_DEPTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire uart_fc_in_t item_i,
  output logic             result_valid_o,
  output uart_fc_out_t     result_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [5:0]  cfg_data_i
);

  logic            in_vld_q;
  uart_fc_in_t     in_q;
  logic            out_vld_q;
  logic [ThrW-1:0] afb_q, rfb_q;
  logic            push, pop;
  tx_cmd_t         tx_cmd;
  ring_res_t       ring_res;
  tx_res_t         tx_res;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Take configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      afb_q <= AssertFreeBelowRst;
      rfb_q <= ReleaseFillBelowRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_ASSERT_FREE_BELOW:  afb_q <= cfg_data_i;
        CFG_RELEASE_FILL_BELOW: rfb_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Register the incoming item
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      in_q <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= start && !busy;
      out_vld_q <= in_vld_q;
    end
  end

  // Decode the operation
  always_comb begin
    push   = 1'b0;
    pop    = 1'b0;
    tx_cmd = '0;
    if (in_vld_q) begin
      unique case (in_q.operation)
        OP_RX_BYTE:       push = 1'b1;
        OP_POP:           pop  = 1'b1;
        OP_SEND: begin
          tx_cmd.send    = 1'b1;
          tx_cmd.attempt = 1'b1;
        end
        OP_RTS_CHANGE,
        OP_TX_EMPTY:      tx_cmd.attempt = 1'b1;
        OP_RESET_RELEASE: begin
          tx_cmd.release_rst = 1'b1;
          tx_cmd.attempt     = 1'b1;
        end
        OP_TX_COMPLETE:   tx_cmd.complete = 1'b1;
        default: ;
      endcase
    end
  end

  uart_fc_ring #(
    .Depth(RING_DEPTH)
  ) u_ring (
    .clk_i,
    .rst_ni,
    .push_i               (push),
    .pop_i                (pop),
    .data_i               (in_q.data_byte),
    .assert_free_below_i  (afb_q),
    .release_fill_below_i (rfb_q),
    .res_o                (ring_res)
  );

  uart_fc_tx u_tx (
    .clk_i,
    .rst_ni,
    .cmd_i      (tx_cmd),
    .data_i     (in_q.data_byte),
    .rts_high_i (in_q.rts_high),
    .tx_ready_i (in_q.tx_ready),
    .res_o      (tx_res)
  );

  // Assemble the result item
  assign result_valid_o      = out_vld_q;
  assign result_o.rx_valid   = ring_res.rx_valid;
  assign result_o.rx_byte    = ring_res.rx_byte;
  assign result_o.tx_valid   = tx_res.tx_valid;
  assign result_o.tx_byte    = tx_res.tx_byte;
  assign result_o.send_done  = tx_res.send_done;
  assign result_o.cts_level  = ring_res.cts_level;
  assign result_o.fill_count = ring_res.fill_count;
  assign result_o.overflow   = ring_res.overflow;

`ifndef SYNTH
  a_item_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##2 result_valid_o)
    else $error("accepted item gave no result");

  a_no_result_unasked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |=> !(ring_res.rx_valid || ring_res.overflow || tx_res.tx_valid
                    || tx_res.send_done))
    else $error("result flags raised without an item");

  a_one_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $countones({result_o.rx_valid, result_o.overflow,
                                   result_o.tx_valid, result_o.send_done}) <= 1)
    else $error("one item caused more than one action");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.overflow |->
      $stable(result_o.fill_count) || $past(!rst_ni))
    else $error("dropped byte changed the fill");
`endif

endmodule

`default_nettype wire

FILE: design/uart_fc_ring.sv
`default_nettype none

module uart_fc_ring import uart_fc_pkg::*; #(
  parameter int unsigned Depth = 32
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire logic            pop_i,
  input  wire logic [7:0]      data_i,
  input  wire logic [ThrW-1:0] assert_free_below_i,
  input  wire logic [ThrW-1:0] release_fill_below_i,
  output ring_res_t            res_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned CmpW = (CntW > ThrW) ? CntW : ThrW;
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  logic [7:0]      mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            cts_q, cts_d;
  logic            do_write, do_read;
  logic            rx_valid_q, overflow_q, overflow_d;
  logic [7:0]      rdata_q;
  logic [CmpW-1:0] free_ext, count_ext;

  assign count_ext = CmpW'(count_d);
  assign free_ext  = CmpW'(Depth) - count_ext;

  // Push, pop and CTS hysteresis
  always_comb begin
    wr_ptr_d   = wr_ptr_q;
    rd_ptr_d   = rd_ptr_q;
    count_d    = count_q;
    cts_d      = cts_q;
    do_write   = 1'b0;
    do_read    = 1'b0;
    overflow_d = 1'b0;
    if (push_i) begin
      if (count_q == Full) begin
        overflow_d = 1'b1;
      end else begin
        do_write = 1'b1;
        wr_ptr_d = (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
        count_d  = count_q + 1'b1;
      end
    end
    if (pop_i && count_q != '0) begin
      do_read  = 1'b1;
      rd_ptr_d = (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
      count_d  = count_q - 1'b1;
    end
    // Assert test reads the fill after the push, release test after the pop
    if (push_i && free_ext < CmpW'(assert_free_below_i)) begin
      cts_d = 1'b1;
    end
    if (do_read && count_ext < CmpW'(release_fill_below_i)) begin
      cts_d = 1'b0;
    end
  end

  // Ring storage; a read never meets a write to the same entry
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      mem_q[wr_ptr_q] <= data_i;
    end
    if (do_read) begin
      rdata_q <= mem_q[rd_ptr_q];
    end
  end

  // Hold pointers, fill and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      count_q    <= '0;
      cts_q      <= 1'b0;
      rx_valid_q <= 1'b0;
      overflow_q <= 1'b0;
    end else begin
      wr_ptr_q   <= wr_ptr_d;
      rd_ptr_q   <= rd_ptr_d;
      count_q    <= count_d;
      cts_q      <= cts_d;
      rx_valid_q <= do_read;
      overflow_q <= overflow_d;
    end
  end

  logic [CmpW-1:0] fill_ext;
  assign fill_ext = CmpW'(count_q);

  assign res_o.rx_valid   = rx_valid_q;
  assign res_o.rx_byte    = rx_valid_q ? rdata_q : 8'd0;
  assign res_o.cts_level  = cts_q;
  assign res_o.fill_count = fill_ext[5:0];
  assign res_o.overflow   = overflow_q;

endmodule

`default_nettype wire

FILE: design/uart_fc_tx.sv
`default_nettype none

module uart_fc_tx import uart_fc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire tx_cmd_t    cmd_i,
  input  wire logic [7:0] data_i,
  input  wire logic       rts_high_i,
  input  wire logic       tx_ready_i,
  output tx_res_t         res_o
);

  logic       pend_q, pend_d;
  logic [7:0] pend_byte_q, pend_byte_d;
  logic       in_rst_q, in_rst_d;
  logic       fire;
  logic       tx_valid_q, done_q;
  logic [7:0] tx_byte_q;

  // Latch a new byte, leave reset, then try the gates in order
  always_comb begin
    pend_d      = pend_q;
    pend_byte_d = pend_byte_q;
    in_rst_d    = in_rst_q;
    fire        = 1'b0;
    if (cmd_i.send) begin
      pend_d      = 1'b1;
      pend_byte_d = data_i;
    end
    if (cmd_i.release_rst) begin
      in_rst_d = 1'b0;
    end
    if (cmd_i.attempt && pend_d && !in_rst_d && !rts_high_i && tx_ready_i) begin
      fire   = 1'b1;
      pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_byte_q <= pend_byte_d;
    tx_byte_q   <= fire ? pend_byte_d : 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= 1'b0;
      in_rst_q   <= 1'b1;
      tx_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      pend_q     <= pend_d;
      in_rst_q   <= in_rst_d;
      tx_valid_q <= fire;
      done_q     <= cmd_i.complete;
    end
  end

  assign res_o.tx_valid  = tx_valid_q;
  assign res_o.tx_byte   = tx_byte_q;
  assign res_o.send_done = done_q;

endmodule

`default_nettype wire

FILE: verif/uart_fc_link_checker.sv
module uart_fc_link_checker import uart_fc_pkg::*; #(
  parameter int unsigned RING_DEPTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic         busy_i,
  input  uart_fc_in_t  item_i,
  input  logic         res_valid_i,
  input  uart_fc_out_t res_i,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [5:0]   cfg_data_i,
  output int unsigned  fail_count_o,
  output int unsigned  due_count_o
);

  timeunit 1ns;
  timeprecision 1ps;

  // Own copy of the link end state
  logic [7:0]  ring_q [RING_DEPTH];
  int unsigned wr_ptr;
  int unsigned rd_ptr;
  int unsigned held;
  logic        cts_on;
  logic [7:0]  pend_byte;
  logic        pend_valid;
  logic        link_in_reset;
  logic [5:0]  free_thr;
  logic [5:0]  fill_thr;

  uart_fc_out_t due_results_q [$];
  int unsigned  fail_count = 0;

  initial begin
    fail_count_o = 0;
    due_count_o  = 0;
  end

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("%0t: mismatch on %s, expected %0h, got %0h", $realtime, what, want, got);
    fail_count++;
  endtask

  // Advance the link state by one item and work out its result
  task automatic advance_link(input uart_fc_in_t it, output uart_fc_out_t res);
    logic attempt;
    attempt = 1'b0;
    res     = '0;
    case (it.operation)
      OP_RX_BYTE: begin
        if (held >= RING_DEPTH) begin
          res.overflow = 1'b1;
        end else begin
          ring_q[wr_ptr] = it.data_byte;
          wr_ptr         = (wr_ptr + 1) % RING_DEPTH;
          held++;
        end
        // assert test runs on drops too
        if (RING_DEPTH - held < free_thr) cts_on = 1'b1;
      end
      OP_POP: begin
        if (held > 0) begin
          res.rx_valid = 1'b1;
          res.rx_byte  = ring_q[rd_ptr];
          rd_ptr       = (rd_ptr + 1) % RING_DEPTH;
          held--;
          if (held < fill_thr) cts_on = 1'b0;
        end
      end
      OP_SEND: begin
        pend_byte  = it.data_byte;
        pend_valid = 1'b1;
        attempt    = 1'b1;
      end
      OP_RTS_CHANGE, OP_TX_EMPTY: begin
        attempt = 1'b1;
      end
      OP_RESET_RELEASE: begin
        link_in_reset = 1'b0;
        attempt       = 1'b1;
      end
      OP_TX_COMPLETE: begin
        res.send_done = 1'b1;
      end
      default: ;
    endcase
    // hand over the pending byte only when every gate is open
    if (attempt && pend_valid && !link_in_reset && !it.rts_high && it.tx_ready) begin
      pend_valid   = 1'b0;
      res.tx_valid = 1'b1;
      res.tx_byte  = pend_byte;
    end
    res.cts_level  = cts_on;
    res.fill_count = 6'(held);
  endtask

  // Compare results, follow register writes and predict accepted items
  always @(posedge clk_i or negedge rst_ni) begin : track_link
    uart_fc_out_t want;
    uart_fc_out_t fresh;
    if (!rst_ni) begin
      wr_ptr        = 0;
      rd_ptr        = 0;
      held          = 0;
      cts_on        = 1'b0;
      pend_byte     = '0;
      pend_valid    = 1'b0;
      link_in_reset = 1'b1;
      free_thr      = AssertFreeBelowRst;
      fill_thr      = ReleaseFillBelowRst;
      due_results_q.delete();
    end else begin
      if (res_valid_i) begin
        if (due_results_q.size() == 0) begin
          report_mismatch("result with none due", 0, 1);
        end else begin
          want = due_results_q.pop_front();
          if (res_i.rx_valid !== want.rx_valid)
            report_mismatch("rx_valid", want.rx_valid, res_i.rx_valid);
          if (res_i.rx_byte !== want.rx_byte)
            report_mismatch("rx_byte", want.rx_byte, res_i.rx_byte);
          if (res_i.tx_valid !== want.tx_valid)
            report_mismatch("tx_valid", want.tx_valid, res_i.tx_valid);
          if (res_i.tx_byte !== want.tx_byte)
            report_mismatch("tx_byte", want.tx_byte, res_i.tx_byte);
          if (res_i.send_done !== want.send_done)
            report_mismatch("send_done", want.send_done, res_i.send_done);
          if (res_i.cts_level !== want.cts_level)
            report_mismatch("cts_level", want.cts_level, res_i.cts_level);
          if (res_i.fill_count !== want.fill_count)
            report_mismatch("fill_count", want.fill_count, res_i.fill_count);
          if (res_i.overflow !== want.overflow)
            report_mismatch("overflow", want.overflow, res_i.overflow);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_ASSERT_FREE_BELOW) free_thr = cfg_data_i;
        else if (cfg_index_i == CFG_RELEASE_FILL_BELOW) fill_thr = cfg_data_i;
      end
      if (start_i && !busy_i) begin
        advance_link(item_i, fresh);
        due_results_q.push_back(fresh);
      end
    end
    fail_count_o <= fail_count;
    due_count_o  <= due_results_q.size();
  end

endmodule

FILE: verif/tb_uart_flow_control_fifo_core.sv
module tb_uart_flow_control_fifo_core;

  timeunit 1ns;
  timeprecision 1ps;

  import uart_fc_pkg::*;

  localparam int unsigned RingDepth  = 32;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned PhaseItems = 292;
  localparam logic [2:0]  OpUndefined = 3'd7;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         start = 1'b0;
  logic         busy;
  uart_fc_in_t  item = '0;
  logic         result_valid;
  uart_fc_out_t result;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [5:0]   cfg_data = '0;

  int unsigned fail_count;
  int unsigned due_count;
  int unsigned idle_pct = 0;
  int unsigned items_sent = 0;
  int unsigned settings_used = 0;
  int unsigned stall_cycles = 0;

  always #1 clk_i = ~clk_i;

  uart_flow_control_fifo_core #(
    .RING_DEPTH(RingDepth)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item),
    .result_valid_o(result_valid),
    .result_o      (result),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  uart_fc_link_checker #(
    .RING_DEPTH(RingDepth)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .item_i      (item),
    .res_valid_i (result_valid),
    .res_i       (result),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .fail_count_o(fail_count),
    .due_count_o (due_count)
  );

  // Stop the run when nothing has moved for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic uart_fc_in_t make_item(input logic [2:0] op, input logic [7:0] data,
                                            input logic rts, input logic ready);
    uart_fc_in_t it;
    it.operation = op;
    it.data_byte = data;
    it.rts_high  = rts;
    it.tx_ready  = ready;
    return it;
  endfunction

  // Offer one item, idling first at the current rate, and hold until taken
  task automatic push_item(input uart_fc_in_t it);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk_i); while (busy);
    items_sent++;
  endtask

  // Hold off the sender until every outstanding result has come back
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (due_count != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write both thresholds back to back on the register channel
  task automatic set_thresholds(input logic [5:0] free_below, input logic [5:0] fill_below);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_ASSERT_FREE_BELOW;
    cfg_data  <= free_below;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_index <= CFG_RELEASE_FILL_BELOW;
    cfg_data  <= fill_below;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [2:0] pick_tx_op();
    int unsigned t;
    t = $urandom_range(19);
    if (t < 6) return OP_SEND;
    else if (t < 9) return OP_RTS_CHANGE;
    else if (t < 13) return OP_TX_EMPTY;
    else if (t < 15) return OP_RESET_RELEASE;
    else if (t < 19) return OP_TX_COMPLETE;
    else return OpUndefined;
  endfunction

  // Random traffic in bursts that fill, drain or mix the ring
  task automatic run_random(input int unsigned n_items);
    int unsigned mode;
    int unsigned pick;
    logic [2:0]  op;
    mode = 0;
    for (int unsigned k = 0; k < n_items; k++) begin
      if (k % 40 == 0) mode = $urandom_range(2);
      pick = $urandom_range(99);
      case (mode)
        0: op = (pick < 75) ? OP_RX_BYTE : (pick < 82) ? OP_POP : pick_tx_op();
        1: op = (pick < 75) ? OP_POP : (pick < 82) ? OP_RX_BYTE : pick_tx_op();
        default: op = (pick < 30) ? OP_RX_BYTE : (pick < 55) ? OP_POP : pick_tx_op();
      endcase
      push_item(make_item(op, 8'($urandom), $urandom_range(99) < 40,
                          $urandom_range(99) < 70));
    end
  endtask

  initial begin
    logic [7:0]  rx_bytes [5];
    int unsigned free_tbl [6];
    int unsigned fill_tbl [6];
    rx_bytes = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F};
    free_tbl = '{32, 1, 12, 32, 1, 0};
    fill_tbl = '{32, 0, 20, 0, 32, 0};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: transmit gates in order, replacement, idle retries, odd codes
    push_item(make_item(OP_POP, 8'hFF, 1'b1, 1'b1));
    push_item(make_item(OP_SEND, 8'hA5, 1'b0, 1'b1));
    push_item(make_item(OP_TX_EMPTY, 8'h00, 1'b0, 1'b1));
    push_item(make_item(OP_RESET_RELEASE, 8'h00, 1'b1, 1'b1));
    push_item(make_item(OP_RTS_CHANGE, 8'h00, 1'b0, 1'b0));
    push_item(make_item(OP_TX_EMPTY, 8'h00, 1'b0, 1'b1));
    push_item(make_item(OP_TX_EMPTY, 8'hFF, 1'b0, 1'b1));
    push_item(make_item(OP_SEND, 8'h00, 1'b0, 1'b1));
    push_item(make_item(OP_SEND, 8'hFF, 1'b1, 1'b1));
    push_item(make_item(OP_SEND, 8'h5A, 1'b0, 1'b0));
    push_item(make_item(OP_RTS_CHANGE, 8'h00, 1'b0, 1'b1));
    push_item(make_item(OP_RESET_RELEASE, 8'h00, 1'b0, 1'b1));
    push_item(make_item(OP_TX_COMPLETE, 8'hFF, 1'b1, 1'b0));
    push_item(make_item(OpUndefined, 8'hFF, 1'b1, 1'b1));
    // Directed: byte extremes through the ring, then one pop too many
    foreach (rx_bytes[i]) push_item(make_item(OP_RX_BYTE, rx_bytes[i], 1'b0, 1'b0));
    repeat (6) push_item(make_item(OP_POP, 8'h00, 1'b0, 1'b0));
    drain_results();

    // Random phases, thresholds changed only once the link is idle
    free_tbl[5] = $urandom_range(32, 1);
    fill_tbl[5] = $urandom_range(32, 0);
    for (int ph = 0; ph < 6; ph++) begin
      set_thresholds(6'(free_tbl[ph]), 6'(fill_tbl[ph]));
      idle_pct = (ph < 2) ? 24 : (ph < 4) ? 69 : 0;
      run_random(PhaseItems);
      drain_results();
    end

    $display("covered %0d items over %0d threshold settings plus reset values,",
             items_sent, settings_used);
    $display("with the sender idling at 24, 69 and 0 percent");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
